>>> hw/rtl/stsg_pkg.sv
// ----------------------------------------------------------------------------
// stsg_pkg
// Shared widths, constants and types of the sine tone sample generator.
// ----------------------------------------------------------------------------
package stsg_pkg;

	localparam int AMP_W       = 15;
	localparam int HZ_W        = 16;
	localparam int SAMPLE_W    = 16;
	localparam int MAG_W       = 15;
	localparam int BYTE_W      = 8;
	localparam int FULL_SCALE  = 32767;
	localparam int HALF_SCALE  = 16384;
	localparam int PROD_SHIFT  = 15;
	localparam int RECIP_SHIFT = 17;
	localparam int HZ_Q_W      = 7;
	localparam int MID_DEPTH   = 8;
	localparam int OUT_DEPTH   = 16;
	localparam real PI_HALF    = 1.5707963267948966;

	typedef logic [AMP_W-1:0] amp_t;
	typedef logic [HZ_W-1:0] hz_t;

	typedef struct packed {
		logic [BYTE_W-1:0] high_byte;
		logic [BYTE_W-1:0] low_byte;
	} sample_bytes_t;

	typedef struct packed {
		logic             negative;
		logic [MAG_W-1:0] magnitude;
	} rom_entry_t;

endpackage

>>> hw/rtl/stsg_fifo.sv
// ----------------------------------------------------------------------------
// stsg_fifo
// Small register-based queue with count tracking, used between the stages.
// ----------------------------------------------------------------------------
module stsg_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign rd_data = mem_q[rd_ptr_q];
	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(wr_en) - CNT_W'(rd_en);
		end
	end

endmodule

>>> hw/rtl/stsg_front.sv
// ----------------------------------------------------------------------------
// stsg_front
// Accepts ticks, reduces the tone step modulo the sample rate and runs the
// phase accumulator, restarting it at the first sample of a note.
// ----------------------------------------------------------------------------
module stsg_front import stsg_pkg::*; #(
	parameter int TICK_RATE = 96000,
	localparam int PHASE_W = $clog2(TICK_RATE)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  amp_t                     amplitude,
	input  hz_t                      tone_hz,
	input  logic                     note_start,
	input  logic                     mid_pop,
	output logic                     mid_wr_en,
	output logic [PHASE_W+AMP_W-1:0] mid_wr_data
);

	localparam int REM_W  = PHASE_W + 1;
	localparam int HZ_K   = (1 << RECIP_SHIFT) / TICK_RATE;
	localparam int HZ_P_W = RECIP_SHIFT + HZ_Q_W;
	localparam int CNT_W  = $clog2(MID_DEPTH + 1);

	logic               accept;
	logic [CNT_W-1:0]   cnt_q;
	logic               v_s1, v_s2, v_s3;
	amp_t               amp_s1, amp_s2, amp_s3;
	logic               start_s1, start_s2, start_s3;
	hz_t                hz_s1;
	logic [HZ_P_W-1:0]  hz_prod_s1;
	logic [REM_W-1:0]   hz_rem_s2;
	logic [PHASE_W-1:0] hz_mod_s3;
	logic [HZ_Q_W-1:0]  hz_quo;
	logic [31:0]        hz_diff;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] phase_use;
	logic [REM_W-1:0]   phase_sum;

	// Credits cover the items in flight here plus those held in the queue.
	assign full   = (cnt_q == CNT_W'(MID_DEPTH));
	assign accept = push && !full;

	assign hz_quo  = hz_prod_s1[RECIP_SHIFT +: HZ_Q_W];
	assign hz_diff = 32'(hz_s1) - 32'(hz_quo) * 32'(TICK_RATE);

	assign phase_use = start_s3 ? '0 : phase_q;
	assign phase_sum = REM_W'(phase_use) + REM_W'(hz_mod_s3);

	assign mid_wr_en   = v_s3;
	assign mid_wr_data = {phase_use, amp_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			phase_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(accept) - CNT_W'(mid_pop);
			v_s1  <= accept;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			if (v_s3) begin
				phase_q <= (phase_sum >= REM_W'(TICK_RATE)) ?
					PHASE_W'(phase_sum - REM_W'(TICK_RATE)) : phase_sum[PHASE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		hz_s1      <= tone_hz;
		hz_prod_s1 <= HZ_P_W'(tone_hz * HZ_K);
		amp_s1     <= amplitude;
		start_s1   <= note_start;

		hz_rem_s2 <= hz_diff[REM_W-1:0];
		amp_s2    <= amp_s1;
		start_s2  <= start_s1;

		hz_mod_s3 <= (hz_rem_s2 >= REM_W'(TICK_RATE)) ?
			PHASE_W'(hz_rem_s2 - REM_W'(TICK_RATE)) : hz_rem_s2[PHASE_W-1:0];
		amp_s3    <= amp_s2;
		start_s3  <= start_s2;
	end

endmodule

>>> hw/rtl/stsg_back.sv
// ----------------------------------------------------------------------------
// stsg_back
// Turns a phase into a table angle, looks up the sine, scales it by the
// amplitude and splits the signed sample into bytes.
// ----------------------------------------------------------------------------
module stsg_back import stsg_pkg::*; #(
	parameter int TICK_RATE = 96000,
	parameter int ANGLE_STEPS = 4096,
	localparam int PHASE_W = $clog2(TICK_RATE)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     mid_empty,
	input  logic [PHASE_W+AMP_W-1:0] mid_rd_data,
	output logic                     mid_pop,
	input  logic                     out_pop,
	output logic                     out_wr_en,
	output sample_bytes_t            out_wr_data
);

	localparam int IDX_W       = $clog2(ANGLE_STEPS);
	localparam int PN_W        = PHASE_W + IDX_W + 1;
	localparam int PK_W        = RECIP_SHIFT + IDX_W;
	localparam longint IDX_K   = (longint'(ANGLE_STEPS) << RECIP_SHIFT) / TICK_RATE;
	localparam int CNT_W       = $clog2(OUT_DEPTH + 1);
	localparam int PROD_W      = AMP_W + MAG_W;

	rom_entry_t         rom_tbl [ANGLE_STEPS];
	logic [CNT_W-1:0]   cnt_q;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [PHASE_W-1:0] phase_s1;
	amp_t               amp_s1, amp_s2, amp_s3, amp_s4, amp_s5;
	logic [PK_W-1:0]    prod_k_s2;
	logic [PN_W-1:0]    prod_n_s2, prod_n_s3;
	logic [IDX_W-1:0]   q_est;
	logic [IDX_W-1:0]   q_est_s3;
	logic [PN_W-1:0]    q_sr_s3;
	logic [PN_W-1:0]    rem;
	logic [IDX_W-1:0]   idx;
	logic [IDX_W-1:0]   idx_s4;
	rom_entry_t         rom_s5;
	logic [PROD_W-1:0]  mul_s6;
	logic               neg_s6;
	logic [MAG_W-1:0]   scaled;
	logic [SAMPLE_W-1:0] sample;

	// Each entry holds the sign and rounded magnitude of the full-scale sine.
	for (genvar gi = 0; gi < ANGLE_STEPS; gi++) begin : g_rom
		localparam int T    = 4 * gi;
		localparam int QUAD = (T / ANGLE_STEPS) % 4;
		localparam int R    = T % ANGLE_STEPS;
		localparam int M    = (QUAD % 2 == 1) ? ANGLE_STEPS - R : R;
		localparam real ANG = PI_HALF * M / ANGLE_STEPS;
		localparam int RAW  = $rtoi(FULL_SCALE * $sin(ANG) + 0.5);
		localparam int MAG  = (M == 0) ? 0 :
			(M >= ANGLE_STEPS) ? FULL_SCALE :
			(3 * M == ANGLE_STEPS) ? HALF_SCALE :
			(RAW > FULL_SCALE) ? FULL_SCALE : RAW;
		assign rom_tbl[gi] = '{negative: (QUAD >= 2), magnitude: MAG_W'(MAG)};
	end

	assign mid_pop = !mid_empty && (cnt_q != CNT_W'(OUT_DEPTH));

	assign q_est = prod_k_s2[RECIP_SHIFT +: IDX_W];
	assign rem   = prod_n_s3 - q_sr_s3;
	assign idx   = (rem >= PN_W'(TICK_RATE)) ? q_est_s3 + IDX_W'(1) : q_est_s3;

	assign scaled      = mul_s6[PROD_SHIFT +: MAG_W];
	assign sample      = neg_s6 ? SAMPLE_W'(0) - SAMPLE_W'(scaled) : SAMPLE_W'(scaled);
	assign out_wr_en   = v_s6;
	assign out_wr_data = sample_bytes_t'(sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(mid_pop) - CNT_W'(out_pop);
			v_s1  <= mid_pop;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		phase_s1 <= mid_rd_data[PHASE_W+AMP_W-1:AMP_W];
		amp_s1   <= mid_rd_data[AMP_W-1:0];

		prod_k_s2 <= PK_W'(longint'(phase_s1) * IDX_K);
		prod_n_s2 <= PN_W'(longint'(phase_s1) * longint'(ANGLE_STEPS));
		amp_s2    <= amp_s1;

		q_est_s3  <= q_est;
		q_sr_s3   <= PN_W'(longint'(q_est) * longint'(TICK_RATE));
		prod_n_s3 <= prod_n_s2;
		amp_s3    <= amp_s2;

		idx_s4 <= idx;
		amp_s4 <= amp_s3;

		rom_s5 <= rom_tbl[idx_s4];
		amp_s5 <= amp_s4;

		mul_s6 <= PROD_W'(amp_s5) * PROD_W'(rom_s5.magnitude);
		neg_s6 <= rom_s5.negative;
	end

endmodule

>>> hw/rtl/sine_tone_sample_generator.sv
// ----------------------------------------------------------------------------
// sine_tone_sample_generator
// Direct digital synthesis of a sine tone, one 16-bit sample per tick.
// ----------------------------------------------------------------------------
// Each pushed tick yields one signed sample, amplitude times the sine of the
// current phase, delivered as a low and a high byte. The phase counter runs
// modulo TICK_RATE, restarts at zero when note_start is set and advances
// by tone_hz after every sample. The block takes one tick per clock cycle
// and delivers one sample per clock cycle as long as full stays low and
// samples are popped. That rate is set by the phase accumulator, which
// does one add and one wrap per tick, while the phase-to-angle division,
// the sine table read and the amplitude multiply are pipelined behind it.
// full rises only when downstream stops popping.
// ----------------------------------------------------------------------------
module sine_tone_sample_generator import stsg_pkg::*; #(
	parameter int TICK_RATE = 96000,
	parameter int ANGLE_STEPS = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [AMP_W-1:0]  amplitude,
	input  logic [HZ_W-1:0]   tone_hz,
	input  logic              note_start,
	output logic              empty,
	input  logic              pop,
	output logic [BYTE_W-1:0] low_byte,
	output logic [BYTE_W-1:0] high_byte
);

	localparam int PHASE_W = $clog2(TICK_RATE);
	localparam int MID_W   = PHASE_W + AMP_W;

	logic             mid_wr_en;
	logic [MID_W-1:0] mid_wr_data;
	logic             mid_pop;
	logic [MID_W-1:0] mid_rd_data;
	logic             mid_empty;
	logic             mid_full;
	logic             out_wr_en;
	sample_bytes_t    out_wr_data;
	logic             out_pop;
	sample_bytes_t    out_rd_data;
	logic             out_full;

	assign out_pop   = pop && !empty;
	assign low_byte  = out_rd_data.low_byte;
	assign high_byte = out_rd_data.high_byte;

	stsg_front #(
		.TICK_RATE(TICK_RATE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.amplitude  (amplitude),
		.tone_hz    (tone_hz),
		.note_start (note_start),
		.mid_pop    (mid_pop),
		.mid_wr_en  (mid_wr_en),
		.mid_wr_data(mid_wr_data)
	);

	stsg_fifo #(
		.WIDTH(MID_W),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mid_wr_en),
		.wr_data(mid_wr_data),
		.rd_en  (mid_pop),
		.rd_data(mid_rd_data),
		.empty  (mid_empty),
		.full   (mid_full)
	);

	stsg_back #(
		.TICK_RATE(TICK_RATE),
		.ANGLE_STEPS(ANGLE_STEPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mid_empty  (mid_empty),
		.mid_rd_data(mid_rd_data),
		.mid_pop    (mid_pop),
		.out_pop    (out_pop),
		.out_wr_en  (out_wr_en),
		.out_wr_data(out_wr_data)
	);

	stsg_fifo #(
		.WIDTH(SAMPLE_W),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (out_wr_en),
		.wr_data(out_wr_data),
		.rd_en  (out_pop),
		.rd_data(out_rd_data),
		.empty  (empty),
		.full   (out_full)
	);

	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(mid_wr_en && mid_full))
		else $error("Middle queue written while full.");

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_wr_en && out_full))
		else $error("Result queue written while full.");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		mid_wr_en |-> (mid_wr_data[MID_W-1:AMP_W] < PHASE_W'(TICK_RATE)))
		else $error("Phase handed to the back end is not below the sample rate.");

endmodule

>>> tb/tone_sample_checker.sv
// ----------------------------------------------------------------------------
// tone_sample_checker
// Watches the tick and sample channels of the sine tone generator, computes
// the sample that each accepted tick must produce and compares it byte by
// byte with the samples popped from the block, oldest first.
// ----------------------------------------------------------------------------
module tone_sample_checker import stsg_pkg::*; #(
	parameter int TICK_RATE = 96000,
	parameter int ANGLE_STEPS = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  amp_t              amplitude,
	input  hz_t               tone_hz,
	input  logic              note_start,
	input  logic              empty,
	input  logic              pop,
	input  logic [BYTE_W-1:0] low_byte,
	input  logic [BYTE_W-1:0] high_byte,
	output int                error_count,
	output int                samples_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;
	localparam int        REPORT_CAP  = 100;

	int unsigned   sine_mag [0:ANGLE_STEPS];
	logic [16:0]   phase_acc;
	sample_bytes_t awaited_samples [$];
	sample_bytes_t oldest;
	int            sample_index;

	function automatic bit [63:0] q62_mul(input bit [63:0] a, input bit [63:0] b);
		bit [127:0] wide;
		wide = {64'd0, a} * {64'd0, b};
		return wide[125:62];
	endfunction

	// Magnitude of the sine at (pi/2)*m/n in full-scale units, rounded half up,
	// from a Taylor series evaluated in Q62 fixed point.
	function automatic int unsigned quarter_sine_mag(input bit [63:0] m, input bit [63:0] n);
		bit [127:0] wide;
		bit [63:0]  x;
		bit [63:0]  x2;
		bit [63:0]  term;
		bit [63:0]  pos;
		bit [63:0]  neg;
		bit [63:0]  s;
		bit [63:0]  ip;
		if (m == 0)
			return 0;
		if (m >= n)
			return FULL_SCALE;
		if (3 * m == n)
			return HALF_SCALE;
		wide = {64'd0, PI_HALF_Q62} * {64'd0, m};
		wide = wide / {64'd0, n};
		x = wide[63:0];
		x2 = q62_mul(x, x);
		pos = x;
		neg = 0;
		term = x;
		for (int k = 1; k < 40; k++) begin
			term = q62_mul(term, x2) / ((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				neg += term;
			else
				pos += term;
		end
		s = (pos > neg) ? pos - neg : 64'd0;
		wide = {64'd0, s} * 128'(FULL_SCALE);
		ip = wide[125:62];
		if (wide[61])
			ip++;
		if (ip > FULL_SCALE)
			ip = FULL_SCALE;
		return ip[31:0];
	endfunction

	function automatic sample_bytes_t predict_sample(input amp_t amp, input hz_t hz,
			input logic restart);
		longint unsigned angle;
		longint unsigned t;
		longint unsigned quad;
		longint unsigned r;
		longint unsigned m;
		int unsigned     prod;
		logic [SAMPLE_W-1:0] sample;
		sample_bytes_t   bytes;
		if (restart)
			phase_acc = '0;
		angle = 64'(phase_acc);
		angle = angle * ANGLE_STEPS / TICK_RATE;
		if (angle >= ANGLE_STEPS)
			angle = ANGLE_STEPS - 1;
		t = 4 * angle;
		quad = (t / ANGLE_STEPS) % 4;
		r = t % ANGLE_STEPS;
		m = quad[0] ? ANGLE_STEPS - r : r;
		prod = amp * sine_mag[m];
		prod = prod >> PROD_SHIFT;
		sample = prod[SAMPLE_W-1:0];
		if (quad >= 2)
			sample = -sample;
		bytes.low_byte = sample[7:0];
		bytes.high_byte = sample[15:8];
		phase_acc = 17'((phase_acc + hz) % TICK_RATE);
		return bytes;
	endfunction

	task automatic report_mismatch(input string what);
		if (error_count < REPORT_CAP)
			$display("%0t ns: sample %0d: %s", $time, sample_index, what);
		error_count++;
	endtask

	initial begin
		for (int m = 0; m <= ANGLE_STEPS; m++)
			sine_mag[m] = quarter_sine_mag(64'(m), 64'(ANGLE_STEPS));
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc = '0;
			awaited_samples.delete();
			samples_in_flight = 0;
			error_count = 0;
			sample_index = 0;
		end else begin
			if (pop && !empty) begin
				if (awaited_samples.size() == 0) begin
					report_mismatch($sformatf("unexpected transaction %h%h", high_byte, low_byte));
				end else begin
					oldest = awaited_samples.pop_front();
					samples_in_flight--;
					if (low_byte !== oldest.low_byte)
						report_mismatch($sformatf("low_byte %h, want %h", low_byte,
							oldest.low_byte));
					if (high_byte !== oldest.high_byte)
						report_mismatch($sformatf("high_byte %h, want %h", high_byte,
							oldest.high_byte));
				end
				sample_index++;
			end
			if (push && !full) begin
				awaited_samples.push_back(predict_sample(amplitude, tone_hz, note_start));
				samples_in_flight++;
			end
		end
	end

endmodule

>>> tb/tb_sine_tone_sample_generator.sv
// ----------------------------------------------------------------------------
// tb_sine_tone_sample_generator
// Drives ticks into the sine tone sample generator and pops its samples.
// ----------------------------------------------------------------------------
// A directed opening hits the quadrant angles, the phase wrap, the largest
// phase, aliased and full-range tones and alternating bit patterns. Random
// notes of constant amplitude and tone follow, mixed with loose ticks. Both
// sides idle at random; the sample side also holds off long enough to fill
// the block, and the tick side once waits for the block to drain. The
// checker beside the block predicts and compares every sample.
// ----------------------------------------------------------------------------
module tb_sine_tone_sample_generator;
	import stsg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TICK_COUNT = 1000;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	amp_t              amplitude;
	hz_t               tone_hz;
	logic              note_start;
	logic              empty;
	logic              pop;
	logic [BYTE_W-1:0] low_byte;
	logic [BYTE_W-1:0] high_byte;
	int                error_count;
	int                samples_in_flight;
	logic              hold_request;
	bit                gaps_on;
	int                ticks_sent;

	sine_tone_sample_generator uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.amplitude  (amplitude),
		.tone_hz    (tone_hz),
		.note_start (note_start),
		.empty      (empty),
		.pop        (pop),
		.low_byte   (low_byte),
		.high_byte  (high_byte)
	);

	tone_sample_checker sample_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.amplitude         (amplitude),
		.tone_hz           (tone_hz),
		.note_start        (note_start),
		.empty             (empty),
		.pop               (pop),
		.low_byte          (low_byte),
		.high_byte         (high_byte),
		.error_count       (error_count),
		.samples_in_flight (samples_in_flight)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic send_tick(input amp_t amp, input hz_t hz, input logic restart);
		while (gaps_on && $urandom_range(99) < 28) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		amplitude <= amp;
		tone_hz <= hz;
		note_start <= restart;
		@(posedge clk);
		while (full)
			@(posedge clk);
		ticks_sent++;
	endtask

	initial begin
		amp_t        note_amp;
		hz_t         note_hz;
		int unsigned note_len;
		bit          hold_sent;
		bit          drain_done;
		hold_sent = 1'b0;
		drain_done = 1'b0;
		gaps_on = 1'b1;
		ticks_sent = 0;
		arst_n <= 1'b0;
		push <= 1'b0;
		amplitude <= '0;
		tone_hz <= '0;
		note_start <= 1'b0;
		hold_request <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tick(15'd32767, 16'd24000, 1'b1);
		repeat (3) send_tick(15'd32767, 16'd24000, 1'b0);
		send_tick(15'd0, 16'd24000, 1'b0);
		send_tick(15'd32767, 16'd0, 1'b1);
		send_tick(15'd32767, 16'd65535, 1'b0);
		send_tick(15'd32767, 16'd30464, 1'b0);
		send_tick(15'd32767, 16'd1, 1'b0);
		send_tick(15'd1, 16'd1, 1'b0);
		send_tick(15'd20000, 16'd60000, 1'b1);
		repeat (2) send_tick(15'd20000, 16'd60000, 1'b0);
		send_tick(15'h2AAA, 16'hAAAA, 1'b1);
		send_tick(15'h5555, 16'h5555, 1'b0);
		send_tick(15'h7FFF, 16'hFFFF, 1'b0);
		send_tick(15'd32767, 16'd48000, 1'b1);
		send_tick(15'd32767, 16'd48000, 1'b0);
		send_tick(15'd32767, 16'd8000, 1'b1);
		send_tick(15'd32767, 16'd8000, 1'b0);

		while (ticks_sent < TICK_COUNT) begin
			gaps_on = !(ticks_sent >= 450 && ticks_sent < 600);
			if (!hold_sent && ticks_sent >= 300) begin
				hold_request <= 1'b1;
				hold_sent = 1'b1;
			end
			if (!drain_done && ticks_sent >= 750) begin
				push <= 1'b0;
				@(posedge clk);
				while (samples_in_flight != 0)
					@(posedge clk);
				drain_done = 1'b1;
			end
			if ($urandom_range(99) < 85) begin
				note_len = $urandom_range(48, 1);
				note_amp = amp_t'($urandom());
				if ($urandom_range(3) == 0)
					note_hz = hz_t'($urandom());
				else
					note_hz = hz_t'($urandom_range(48000));
				for (int i = 0; i < note_len; i++)
					send_tick(note_amp, note_hz, i == 0);
			end else begin
				repeat ($urandom_range(4, 1))
					send_tick(amp_t'($urandom()), hz_t'($urandom()), 1'($urandom_range(1)));
			end
		end

		push <= 1'b0;
		@(posedge clk);
		while (samples_in_flight != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("sine_tone_sample_generator test passed");
		else
			$display("sine_tone_sample_generator test failed");
		$finish;
	end

	initial begin
		int unsigned rx_cycle;
		int unsigned hold_left;
		bit          hold_done;
		rx_cycle = 0;
		hold_left = 0;
		hold_done = 1'b0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (hold_left != 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (hold_request && !hold_done) begin
				pop <= 1'b0;
				hold_left = 250;
				hold_done = 1'b1;
			end else if (rx_cycle >= 900 && rx_cycle < 1300) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(99) >= 28);
			end
		end
	end

	initial begin
		#2000000;
		$display("sine_tone_sample_generator test failed");
		$finish;
	end

endmodule
